// ----- rtl/bctt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag table package
// Shared codes, table entry layout, queued item layout and back-end states.
// ----------------------------------------------------------------------------
package bctt_pkg;

   localparam logic OP_READ    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_UNUSED    = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0]  dev;
      logic [31:0] block_number;
      logic [7:0]  count;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  dev;
      logic [31:0] block_number;
      logic [3:0]  slot;
      logic        slot_in_range;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_RDATA,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/bctt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one lookup or release request.
// ----------------------------------------------------------------------------
interface bctt_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  dev;
   logic [31:0] block_number;
   logic [3:0]  slot;

   modport source (output valid, op, dev, block_number, slot, input ready);
   modport sink   (input valid, op, dev, block_number, slot, output ready);
endinterface

// ----- rtl/bctt_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface bctt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] slot_out;
   logic       hit;
   logic       fill_needed;
   logic [1:0] status;

   modport source (output valid, slot_out, hit, fill_needed, status, input ready);
   modport sink   (input valid, slot_out, hit, fill_needed, status, output ready);
endinterface

// ----- rtl/bctt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bctt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag table front end
// Takes requests, checks the release slot range and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bctt_front #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   bctt_req_if.sink           req_chan,
   output bctt_pkg::item_type head,
   output logic               head_valid,
   input  logic               pop
);

   bctt_pkg::item_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   bctt_pkg::item_type item;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;

   always_comb begin
      item.op            = req_chan.op;
      item.dev           = req_chan.dev;
      item.block_number  = req_chan.block_number;
      item.slot          = req_chan.slot;
      item.slot_in_range = (int'(req_chan.slot) < SLOTS);
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);

endmodule

// ----- rtl/bctt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag table back end
// Reads scan the slot table for a tag match and the first idle slot, releases
// read their slot; both update the user count and register the response.
// ----------------------------------------------------------------------------
module bctt_back #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  bctt_pkg::item_type head,
   input  logic               head_valid,
   output logic               pop,
   bctt_rsp_if.source         rsp_chan
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ENTRY_W = $bits(bctt_pkg::entry_type);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   bctt_pkg::state_type state_ff, state_in;
   bctt_pkg::item_type  cur_ff, cur_in;
   bctt_pkg::entry_type sel_ff, sel_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [SLOT_W-1:0]   addr_d_ff;
   logic                eval_ff, eval_in;
   logic                found_match_ff, found_match_in;
   logic                found_free_ff, found_free_in;
   logic [SLOT_W-1:0]   match_slot_ff, match_slot_in;
   logic [SLOT_W-1:0]   free_slot_ff, free_slot_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          slot_out_ff, slot_out_in;
   logic                hit_ff, hit_in;
   logic                fill_ff, fill_in;
   logic [1:0]          status_ff, status_in;

   logic                out_free;
   logic                load;
   logic [SLOT_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   bctt_pkg::entry_type rd_entry;
   logic                wr_en;
   logic [SLOT_W-1:0]   pick;
   bctt_pkg::entry_type wr_entry;
   logic [7:0]          cnt;
   logic                found;
   logic                unused;

   bctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pick),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Slots never written read as the reset value of zero.
   assign rd_entry = valid_ff[addr_d_ff] ? bctt_pkg::entry_type'(rd_data) : '0;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bctt_pkg::ST_IDLE: begin
            if (head_valid) begin
               state_in = (head.op == bctt_pkg::OP_READ) ? bctt_pkg::ST_SCAN
                                                         : bctt_pkg::ST_RDATA;
            end
         end
         bctt_pkg::ST_SCAN: begin
            if (scan_ff == LAST_SLOT) begin
               state_in = bctt_pkg::ST_LAST;
            end
         end
         bctt_pkg::ST_LAST:  state_in = bctt_pkg::ST_FINISH;
         bctt_pkg::ST_RDATA: state_in = bctt_pkg::ST_FINISH;
         bctt_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bctt_pkg::ST_IDLE;
            end
         end
         default: state_in = bctt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      load           = 1'b0;
      wr_en          = 1'b0;
      rd_addr        = scan_ff;
      cur_in         = cur_ff;
      sel_in         = sel_ff;
      scan_in        = scan_ff;
      eval_in        = 1'b0;
      found_match_in = found_match_ff;
      found_free_in  = found_free_ff;
      match_slot_in  = match_slot_ff;
      free_slot_in   = free_slot_ff;
      valid_in       = valid_ff;
      slot_out_in    = slot_out_ff;
      hit_in         = hit_ff;
      fill_in        = fill_ff;
      status_in      = status_ff;
      pick           = SLOT_W'(cur_ff.slot);
      cnt            = sel_ff.count;
      found          = 1'b0;
      unused         = 1'b0;
      wr_entry       = sel_ff;

      unique case (state_ff)
         bctt_pkg::ST_IDLE: begin
            rd_addr = SLOT_W'(head.slot);
            if (head_valid) begin
               pop            = 1'b1;
               cur_in         = head;
               scan_in        = '0;
               found_match_in = 1'b0;
               found_free_in  = 1'b0;
            end
         end
         bctt_pkg::ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            eval_in = 1'b1;
         end
         bctt_pkg::ST_LAST: begin
         end
         bctt_pkg::ST_RDATA: begin
            sel_in = rd_entry;
         end
         bctt_pkg::ST_FINISH: begin
            load = out_free;
            if (cur_ff.op == bctt_pkg::OP_READ) begin
               found = found_match_ff || found_free_ff;
               if (found_match_ff) begin
                  pick = match_slot_ff;
                  cnt  = sel_ff.count;
               end else begin
                  pick = free_slot_ff;
                  cnt  = '0;
               end
               wr_entry.dev          = cur_ff.dev;
               wr_entry.block_number = cur_ff.block_number;
               wr_entry.count        = cnt + 8'd1;
               wr_en       = load && found && (cnt != bctt_pkg::COUNT_MAX);
               slot_out_in = found ? 4'(pick) : 4'd0;
               hit_in      = found_match_ff;
               fill_in     = found && (cnt == 8'd0);
               if (!found) begin
                  status_in = bctt_pkg::STATUS_NO_FREE;
               end else if (cnt == bctt_pkg::COUNT_MAX) begin
                  status_in = bctt_pkg::STATUS_SATURATED;
               end else begin
                  status_in = bctt_pkg::STATUS_OK;
               end
            end else begin
               unused         = !cur_ff.slot_in_range || (cnt == 8'd0);
               wr_entry.count = cnt - 8'd1;
               wr_en          = load && !unused;
               slot_out_in    = cur_ff.slot;
               hit_in         = 1'b0;
               fill_in        = 1'b0;
               status_in      = unused ? bctt_pkg::STATUS_UNUSED : bctt_pkg::STATUS_OK;
            end
            if (wr_en) begin
               valid_in[pick] = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (eval_ff) begin
         if (!found_match_ff && (rd_entry.dev == cur_ff.dev)
             && (rd_entry.block_number == cur_ff.block_number)) begin
            found_match_in = 1'b1;
            match_slot_in  = addr_d_ff;
            sel_in         = rd_entry;
         end
         if (!found_free_ff && (rd_entry.count == 8'd0)) begin
            found_free_in = 1'b1;
            free_slot_in  = addr_d_ff;
         end
      end

      rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bctt_pkg::ST_IDLE;
         eval_ff        <= 1'b0;
         found_match_ff <= 1'b0;
         found_free_ff  <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         eval_ff        <= eval_in;
         found_match_ff <= found_match_in;
         found_free_ff  <= found_free_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      sel_ff        <= sel_in;
      scan_ff       <= scan_in;
      addr_d_ff     <= rd_addr;
      match_slot_ff <= match_slot_in;
      free_slot_ff  <= free_slot_in;
      if (load) begin
         slot_out_ff <= slot_out_in;
         hit_ff      <= hit_in;
         fill_ff     <= fill_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.slot_out    = slot_out_ff;
   assign rsp_chan.hit         = hit_ff;
   assign rsp_chan.fill_needed = fill_ff;
   assign rsp_chan.status      = status_ff;

   a_write_in_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bctt_pkg::ST_FINISH))
      else $error("Table write outside the finish state.");

   a_scan_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bctt_pkg::ST_SCAN) |=>
      ((state_ff == bctt_pkg::ST_SCAN) || (state_ff == bctt_pkg::ST_LAST)))
      else $error("Scan left without reaching the last slot.");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bctt_pkg::ST_FINISH) && !out_free) |=>
      ((state_ff == bctt_pkg::ST_FINISH) && $stable(cur_ff)))
      else $error("Finished item lost while the response register was full.");

   a_read_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (cur_ff.op == bctt_pkg::OP_READ)) |-> (wr_entry.count != 8'd0))
      else $error("Read wrote back a zero user count.");

   a_pop_with_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Queue popped while empty.");

endmodule

// ----- rtl/buffer_cache_tag_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache tag table
// A read scans all SLOTS slots through the table RAM read port, one slot per
// cycle; a release reads only its own slot. The back end takes a new request
// only after the previous result is loaded into the response register.
// A two-entry request queue keeps taking transfers while the back end works,
// until it is full. Synchronous reset empties the queue and clears all slot
// valid bits at once, so every tag and user count reads as zero after reset.
// ----------------------------------------------------------------------------
module buffer_cache_tag_table_top #(
   parameter int SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   bctt_req_if.sink   req_chan,
   bctt_rsp_if.source rsp_chan
);

   bctt_pkg::item_type head;
   logic               head_valid;
   logic               pop;

   bctt_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

   bctt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
